[rtl/assert_macros.svh]
// Assertion helpers used by the top-level RTL file of the matrix row transform.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/mx4_pkg.sv]
// Shared constants and helper functions for the 4x4 binary32 row transform.
// No dependencies.
package mx4_pkg;

    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 4;

    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_B_ROW0_COLS01 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_B_ROW0_COLS23 = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B_ROW1_COLS01 = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_B_ROW1_COLS23 = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_B_ROW2_COLS01 = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_B_ROW2_COLS23 = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_B_ROW3_COLS01 = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_B_ROW3_COLS23 = 4'd7;

    // Identity matrix after reset.
    localparam logic [63:0] B_RESET [NUM_REGS] = '{
        64'h0000_0000_3F80_0000, 64'h0000_0000_0000_0000,
        64'h3F80_0000_0000_0000, 64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000, 64'h0000_0000_3F80_0000,
        64'h0000_0000_0000_0000, 64'h3F80_0000_0000_0000
    };

    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        logic       hit;
        n   = 6'd48;
        hit = 1'b0;
        for (int k = 47; k >= 0; k--) begin
            if (!hit && v[k]) begin
                n   = 6'(47 - k);
                hit = 1'b1;
            end
        end
        return n;
    endfunction

    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] n;
        logic       hit;
        n   = 5'd27;
        hit = 1'b0;
        for (int k = 26; k >= 0; k--) begin
            if (!hit && v[k]) begin
                n   = 5'(26 - k);
                hit = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

[rtl/mx4_fmul.sv]
// Two-stage binary32 multiplier with round-to-nearest-even and subnormals.
// Depends on mx4_pkg; stage loads are driven by the parent's pipeline control.
module mx4_fmul (
    input  logic        aclk,
    input  logic        en_a,
    input  logic        en_b,
    input  logic [31:0] x,
    input  logic [31:0] y,
    output logic [31:0] z
);
    import mx4_pkg::*;

    logic [7:0]        ex, ey, eax, eay;
    logic              xnan, ynan, xinf, yinf, xzero, yzero;
    logic signed [9:0] t_next;
    logic [47:0]       prod_next;

    logic              sgn_reg, nan_reg, inf_reg;
    logic signed [9:0] t_reg;
    logic [47:0]       prod_reg;
    logic [31:0]       z_reg;

    logic [5:0]  lz, lsh, rsh;
    logic [9:0]  tneg;
    logic [8:0]  tu, be;
    logic [47:0] pn;
    logic [95:0] wide;
    logic        stk, up, big;
    logic [7:0]  ef;
    logic [30:0] rounded;
    logic [31:0] z_next;

    always_comb begin
        ex    = x[30:23];
        ey    = y[30:23];
        eax   = (ex == 8'd0) ? 8'd1 : ex;
        eay   = (ey == 8'd0) ? 8'd1 : ey;
        xnan  = (ex == 8'hFF) && (x[22:0] != 23'd0);
        ynan  = (ey == 8'hFF) && (y[22:0] != 23'd0);
        xinf  = (ex == 8'hFF) && (x[22:0] == 23'd0);
        yinf  = (ey == 8'hFF) && (y[22:0] == 23'd0);
        xzero = (x[30:0] == 31'd0);
        yzero = (y[30:0] == 31'd0);
        t_next    = $signed({2'b00, eax}) + $signed({2'b00, eay}) - 10'sd127;
        prod_next = {24'd0, (ex != 8'd0), x[22:0]} * {24'd0, (ey != 8'd0), y[22:0]};
    end

    always_ff @(posedge aclk) begin
        if (en_a) begin
            sgn_reg  <= x[31] ^ y[31];
            nan_reg  <= xnan | ynan | (xinf & yzero) | (yinf & xzero);
            inf_reg  <= xinf | yinf;
            t_reg    <= t_next;
            prod_reg <= prod_next;
        end
    end

    // Normalize so the leading one sits at bit 47; a result below the normal range is shifted left
    // only as far as the exponent allows, or right when it is negative, and leaves the exponent field at zero.
    always_comb begin
        lz   = lzc48(prod_reg);
        tu   = t_reg[8:0];
        tneg = -t_reg;
        rsh  = (tneg > 10'd63) ? 6'd63 : tneg[5:0];
        lsh  = ({3'b000, lz} <= tu) ? lz : tu[5:0];
        wide = {prod_reg, 48'd0} >> rsh;
        if (!t_reg[9]) begin
            pn  = prod_reg << lsh;
            stk = 1'b0;
            be  = tu + 9'd1 - {3'b000, lsh};
        end else begin
            pn  = wide[95:48];
            stk = |wide[47:0];
            be  = 9'd0;
        end
        big     = pn[47] && (be >= 9'd255);
        ef      = pn[47] ? be[7:0] : 8'd0;
        up      = pn[23] & ((|pn[22:0]) | stk | pn[24]);
        rounded = {ef, pn[46:24]} + {30'd0, up};
        if (nan_reg) begin
            z_next = CANON_NAN;
        end else if (inf_reg || big) begin
            z_next = {sgn_reg, 8'hFF, 23'd0};
        end else begin
            z_next = {sgn_reg, rounded};
        end
    end

    always_ff @(posedge aclk) begin
        if (en_b) begin
            z_reg <= z_next;
        end
    end

    assign z = z_reg;

endmodule

[rtl/mx4_fadd.sv]
// Two-stage binary32 adder with round-to-nearest-even and subnormals.
// Depends on mx4_pkg; stage loads are driven by the parent's pipeline control.
module mx4_fadd (
    input  logic        aclk,
    input  logic        en_a,
    input  logic        en_b,
    input  logic [31:0] x,
    input  logic [31:0] y,
    output logic [31:0] z
);
    import mx4_pkg::*;

    logic        ge;
    logic [31:0] bx, sm;
    logic [7:0]  ebx, esx, d;
    logic [4:0]  dd;
    logic [26:0] mb, ms, al;
    logic [53:0] wide;
    logic [27:0] sum_next;
    logic        xnan, ynan, xinf, yinf;

    logic [27:0] sum_reg;
    logic [7:0]  e_reg;
    logic        sgn_reg, zsgn_reg, nan_reg, inf_reg, infsgn_reg;
    logic [31:0] z_reg;

    logic [4:0]  lz, lsh;
    logic [7:0]  lim;
    logic [26:0] sn;
    logic [8:0]  e9;
    logic        up, big;
    logic [7:0]  ef;
    logic [30:0] rounded;
    logic [31:0] z_next;

    always_comb begin
        xnan = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
        ynan = (y[30:23] == 8'hFF) && (y[22:0] != 23'd0);
        xinf = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
        yinf = (y[30:23] == 8'hFF) && (y[22:0] == 23'd0);
        ge   = (x[30:0] >= y[30:0]);
        bx   = ge ? x : y;
        sm   = ge ? y : x;
        ebx  = (bx[30:23] == 8'd0) ? 8'd1 : bx[30:23];
        esx  = (sm[30:23] == 8'd0) ? 8'd1 : sm[30:23];
        d    = ebx - esx;
        dd   = (d > 8'd31) ? 5'd31 : d[4:0];
        mb   = {(bx[30:23] != 8'd0), bx[22:0], 3'b000};
        ms   = {(sm[30:23] != 8'd0), sm[22:0], 3'b000};
        // Bits shifted out of the smaller operand fold into the sticky bit.
        wide = {ms, 27'd0} >> dd;
        al   = wide[53:27] | {26'd0, |wide[26:0]};
        if (bx[31] ^ sm[31]) begin
            sum_next = {1'b0, mb} - {1'b0, al};
        end else begin
            sum_next = {1'b0, mb} + {1'b0, al};
        end
    end

    always_ff @(posedge aclk) begin
        if (en_a) begin
            sum_reg    <= sum_next;
            e_reg      <= ebx;
            sgn_reg    <= bx[31];
            zsgn_reg   <= x[31] & y[31];
            nan_reg    <= xnan | ynan | (xinf & yinf & (x[31] ^ y[31]));
            inf_reg    <= xinf | yinf;
            infsgn_reg <= xinf ? x[31] : y[31];
        end
    end

    always_comb begin
        lz  = lzc27(sum_reg[26:0]);
        lim = e_reg - 8'd1;
        lsh = ({3'b000, lz} <= lim) ? lz : lim[4:0];
        if (sum_reg[27]) begin
            sn = {sum_reg[27:2], sum_reg[1] | sum_reg[0]};
            e9 = {1'b0, e_reg} + 9'd1;
        end else begin
            sn = sum_reg[26:0] << lsh;
            e9 = {1'b0, e_reg} - {4'd0, lsh};
        end
        big     = sn[26] && (e9 >= 9'd255);
        ef      = sn[26] ? e9[7:0] : 8'd0;
        up      = sn[2] & (sn[1] | sn[0] | sn[3]);
        rounded = {ef, sn[25:3]} + {30'd0, up};
        if (nan_reg) begin
            z_next = CANON_NAN;
        end else if (inf_reg) begin
            z_next = {infsgn_reg, 8'hFF, 23'd0};
        end else if (sum_reg == 28'd0) begin
            z_next = {zsgn_reg, 31'd0};
        end else if (big) begin
            z_next = {sgn_reg, 8'hFF, 23'd0};
        end else begin
            z_next = {sgn_reg, rounded};
        end
    end

    always_ff @(posedge aclk) begin
        if (en_b) begin
            z_reg <= z_next;
        end
    end

    assign z = z_reg;

endmodule

[rtl/matrix4_row_transform_top.sv]
`include "assert_macros.svh"
// Streaming 4x4 binary32 matrix product: one row of A in, one row of A*B out.
// Depends on mx4_pkg, mx4_fmul, mx4_fadd and assert_macros.svh.
//
// Usage:
//   The matrix B sits in eight 64-bit registers written through the cfg_
//   channel (cfg_index selects the register, two elements per register, the
//   lower column in bits 31:0). Writes to an index of eight or more are
//   dropped. cfg_ready is always high.
//   The s_ channel carries one row of A per beat, the m_ channel one row of
//   the product per beat. Element j is ((a0*b0j + a1*b1j) + a2*b2j) + a3*b3j,
//   each step rounded to nearest even.
//   The path has eight register stages: two for the sixteen multipliers and
//   two for each of the three chained adders.
//   Throughput is one row per cycle while m_ready stays high. Each stage has
//   its own valid bit and loads when it is empty or the stage after it moves,
//   so a stalled receiver backs up the pipeline and empty stages keep taking
//   rows until all eight hold one.
//   Reset clears every valid bit and loads B with the identity matrix.
module matrix4_row_transform_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [31:0]                       s_a_col0,
    input  logic [31:0]                       s_a_col1,
    input  logic [31:0]                       s_a_col2,
    input  logic [31:0]                       s_a_col3,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [31:0]                       m_p_col0,
    output logic [31:0]                       m_p_col1,
    output logic [31:0]                       m_p_col2,
    output logic [31:0]                       m_p_col3,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mx4_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [63:0]                       cfg_data
);
    import mx4_pkg::*;

    logic [63:0] b_reg [NUM_REGS];
    logic [8:1]  v_reg;
    logic [8:1]  en;
    logic [31:0] a_in [4];
    logic [31:0] prod [4][4];
    logic [31:0] s1 [4];
    logic [31:0] s2 [4];
    logic [31:0] s3 [4];
    logic [31:0] p2_d1_reg [4];
    logic [31:0] p2_d2_reg [4];
    logic [31:0] p3_d1_reg [4];
    logic [31:0] p3_d2_reg [4];
    logic [31:0] p3_d3_reg [4];
    logic [31:0] p3_d4_reg [4];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < NUM_REGS; r++) begin
                b_reg[r] <= B_RESET[r];
            end
        end else if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
            b_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    // A stage may load when it is empty or its contents move on.
    always_comb begin
        en[8] = !v_reg[8] || m_ready;
        for (int k = 7; k >= 1; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[1]) begin
                v_reg[1] <= s_valid;
            end
            for (int k = 2; k <= 8; k++) begin
                if (en[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    assign s_ready = en[1];
    assign m_valid = v_reg[8];

    assign a_in[0] = s_a_col0;
    assign a_in[1] = s_a_col1;
    assign a_in[2] = s_a_col2;
    assign a_in[3] = s_a_col3;

    for (genvar i = 0; i < 4; i++) begin : g_row
        for (genvar j = 0; j < 4; j++) begin : g_col
            mx4_fmul u_mul (
                .aclk (aclk),
                .en_a (en[1]),
                .en_b (en[2]),
                .x    (a_in[i]),
                .y    (b_reg[i*2 + j/2][(j%2)*32 +: 32]),
                .z    (prod[i][j])
            );
        end
    end

    for (genvar j = 0; j < 4; j++) begin : g_sum
        // Later products wait in delay registers until the running sum arrives.
        always_ff @(posedge aclk) begin
            if (en[3]) begin
                p2_d1_reg[j] <= prod[2][j];
                p3_d1_reg[j] <= prod[3][j];
            end
            if (en[4]) begin
                p2_d2_reg[j] <= p2_d1_reg[j];
                p3_d2_reg[j] <= p3_d1_reg[j];
            end
            if (en[5]) begin
                p3_d3_reg[j] <= p3_d2_reg[j];
            end
            if (en[6]) begin
                p3_d4_reg[j] <= p3_d3_reg[j];
            end
        end

        mx4_fadd u_add1 (
            .aclk (aclk),
            .en_a (en[3]),
            .en_b (en[4]),
            .x    (prod[0][j]),
            .y    (prod[1][j]),
            .z    (s1[j])
        );

        mx4_fadd u_add2 (
            .aclk (aclk),
            .en_a (en[5]),
            .en_b (en[6]),
            .x    (s1[j]),
            .y    (p2_d2_reg[j]),
            .z    (s2[j])
        );

        mx4_fadd u_add3 (
            .aclk (aclk),
            .en_a (en[7]),
            .en_b (en[8]),
            .x    (s2[j]),
            .y    (p3_d4_reg[j]),
            .z    (s3[j])
        );
    end

    assign m_p_col0 = s3[0];
    assign m_p_col1 = s3[1];
    assign m_p_col2 = s3[2];
    assign m_p_col3 = s3[3];

    `ASSERT_NEXT(a_accept_fills_s1, aclk, aresetn, s_valid && s_ready, v_reg[1])
    `ASSERT_NEXT(a_blocked_stage_holds, aclk, aresetn, v_reg[4] && !en[4], v_reg[4])
    `ASSERT_SAME(a_ready_when_s1_empty, aclk, aresetn, !v_reg[1], s_ready)
    `ASSERT_NEXT(a_cfg_write_b00, aclk, aresetn, cfg_valid && (cfg_index == CFG_B_ROW0_COLS01), b_reg[0] == $past(cfg_data))

endmodule

[tb/sv/tb_matrix4_row_transform_top.sv]
// Self-checking testbench for the streaming 4x4 binary32 row transform.
// Depends on mx4_pkg and the matrix4_row_transform_top RTL.
module tb_matrix4_row_transform_top;
    timeunit 1ns;
    timeprecision 1ps;
    import mx4_pkg::*;

    typedef logic [3:0][31:0] row_t;   // [j] holds column j

    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN_WAIT = 12;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [31:0]          s_a_col0, s_a_col1, s_a_col2, s_a_col3;
    logic                 m_valid;
    logic                 m_ready;
    logic [31:0]          m_p_col0, m_p_col1, m_p_col2, m_p_col3;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [63:0]          cfg_data;

    matrix4_row_transform_top dut (.*);

    row_t        pending_rows[$];
    row_t        expected_rows[$];
    logic [63:0] b_mat[NUM_REGS];
    int          send_idle_pct;
    int          recv_stall_pct;
    logic        s_took;
    int          fail_count;
    int          rows_sent;
    int          rows_checked;
    int          idle_cycles;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Widen binary32 bits to a real; exact, NaN is handled by the caller.
    function automatic real f32_to_real(input logic [31:0] v);
        logic [63:0] d;
        logic [22:0] m;
        int          k;
        m = v[22:0];
        k = 0;
        if (v[30:23] == 8'd0 && m == 23'd0) begin
            d = {v[31], 63'd0};
        end else if (v[30:23] == 8'd0) begin
            while (!m[22]) begin
                m = m << 1;
                k++;
            end
            m = m << 1;
            d = {v[31], 11'(1023 - 127 - k), m, 29'd0};
        end else if (v[30:23] == 8'hFF) begin
            d = {v[31], 11'h7FF, 52'd0};
        end else begin
            d = {v[31], 11'(int'(v[30:23]) - 127 + 1023), v[22:0], 29'd0};
        end
        return $bitstoreal(d);
    endfunction

    // Round a real to binary32 bits, nearest even, with gradual underflow.
    function automatic logic [31:0] real_to_f32(input real r);
        logic [63:0] d, sig, rem, half, q, res;
        int          ex, sh;
        d = $realtobits(r);
        if (d[62:52] == 11'h7FF)
            return (d[51:0] != 0) ? CANON_NAN : {d[63], 8'hFF, 23'd0};
        if (d[62:52] == 11'd0)
            return {d[63], 31'd0};
        ex  = int'(d[62:52]) - 1023;
        sig = {11'd0, 1'b1, d[51:0]};
        sh  = (ex >= -126) ? 29 : 29 + (-126 - ex);
        if (sh > 60)
            return {d[63], 31'd0};
        q    = sig >> sh;
        rem  = sig & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0]))
            q++;
        // A carry out of the significand moves into the exponent by itself.
        if (ex >= -126)
            res = (64'(ex + 127) << 23) + q - (64'd1 << 23);
        else
            res = q;
        if (res >= 64'h7F80_0000)
            res = 64'h7F80_0000;
        return {d[63], res[30:0]};
    endfunction

    function automatic logic is_nan32(input logic [31:0] v);
        return v[30:23] == 8'hFF && v[22:0] != 0;
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] x, input logic [31:0] y);
        if (is_nan32(x) || is_nan32(y))
            return CANON_NAN;
        return real_to_f32(f32_to_real(x) * f32_to_real(y));
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] x, input logic [31:0] y);
        if (is_nan32(x) || is_nan32(y))
            return CANON_NAN;
        return real_to_f32(f32_to_real(x) + f32_to_real(y));
    endfunction

    function automatic row_t product_row(input row_t a);
        row_t        p;
        logic [63:0] reg_val;
        logic [31:0] acc, b;
        for (int j = 0; j < 4; j++) begin
            for (int i = 0; i < 4; i++) begin
                reg_val = b_mat[i * 2 + j / 2];
                b = (j % 2) ? reg_val[63:32] : reg_val[31:0];
                acc = (i == 0) ? fp_mul(a[0], b) : fp_add(acc, fp_mul(a[i], b));
            end
            p[j] = acc;
        end
        return p;
    endfunction

    // Operands drawn from every class: zeros, subnormals, moderate and extreme
    // normals, infinities, NaNs and raw bit patterns.
    function automatic logic [31:0] rand_f32();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0: v = {v[31], 31'd0};
            1: v = {v[31], 8'd0, v[22:0]};
            2: v = {v[31], 8'hFF, 23'd0};
            3: v = {v[31], 8'hFF, v[22:0] | 23'd1};
            4: v = {v[31], 8'(254 - $urandom_range(0, 3)), v[22:0]};
            5: v = {v[31], 8'($urandom_range(1, 4)), v[22:0]};
            6: v = v;
            default: v = {v[31], 8'($urandom_range(112, 142)), v[22:0]};
        endcase
        return v;
    endfunction

    function automatic row_t rand_row();
        row_t r;
        for (int j = 0; j < 4; j++)
            r[j] = rand_f32();
        return r;
    endfunction

    // Driver: a new row goes out once the previous beat has been taken.
    always @(negedge aclk) begin
        row_t nxt;
        logic load;
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (!s_valid || s_took) begin
                load = pending_rows.size() != 0 &&
                       $urandom_range(0, 99) >= send_idle_pct;
                if (load) begin
                    nxt = pending_rows.pop_front();
                    s_a_col0 <= nxt[0];
                    s_a_col1 <= nxt[1];
                    s_a_col2 <= nxt[2];
                    s_a_col3 <= nxt[3];
                end
                s_valid <= load;
            end
        end
    end

    task automatic report_field(input string name, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Monitor: predicts on each accepted input beat, checks each output beat.
    always @(posedge aclk) begin
        row_t a, exp_row;
        if (!aresetn) begin
            s_took      <= 1'b0;
            idle_cycles <= 0;
            for (int r = 0; r < NUM_REGS; r++)
                b_mat[r] = B_RESET[r];
        end else begin
            s_took <= s_valid && s_ready;
            if (cfg_valid && cfg_ready && cfg_index < NUM_REGS)
                b_mat[cfg_index[2:0]] = cfg_data;
            if (s_valid && s_ready) begin
                a = {s_a_col3, s_a_col2, s_a_col1, s_a_col0};
                expected_rows.push_back(product_row(a));
                rows_sent++;
            end
            if (m_valid && m_ready) begin
                if (expected_rows.size() == 0) begin
                    $error("output beat with no row outstanding");
                    fail_count++;
                end else begin
                    exp_row = expected_rows.pop_front();
                    report_field("p_col0", exp_row[0], m_p_col0);
                    report_field("p_col1", exp_row[1], m_p_col1);
                    report_field("p_col2", exp_row[2], m_p_col2);
                    report_field("p_col3", exp_row[3], m_p_col3);
                    rows_checked++;
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
    endtask

    // Loads all of B with one flavor of contents, then pokes an unused index.
    task automatic load_matrix(input int kind);
        logic [CFG_IDX_W-1:0] reg_idx[NUM_REGS];
        logic [63:0]          val;
        reg_idx = '{CFG_B_ROW0_COLS01, CFG_B_ROW0_COLS23, CFG_B_ROW1_COLS01,
                    CFG_B_ROW1_COLS23, CFG_B_ROW2_COLS01, CFG_B_ROW2_COLS23,
                    CFG_B_ROW3_COLS01, CFG_B_ROW3_COLS23};
        for (int r = 0; r < NUM_REGS; r++) begin
            case (kind)
                0: val = 64'd0;
                1: val = '1;
                2: val = {32'h7F7F_FFFF, 32'h0000_0001};
                default: val = {rand_f32(), rand_f32()};
            endcase
            write_reg(reg_idx[r], val);
        end
        write_reg(CFG_IDX_W'(NUM_REGS + $urandom_range(0, 7)), {$urandom, $urandom});
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_rows.size() != 0 || s_valid || expected_rows.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    initial begin
        int modes[4][2];
        modes = '{'{0, 0}, '{69, 0}, '{0, 69}, '{17, 17}};
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        m_ready        = 1'b0;
        s_a_col0       = '0;
        s_a_col1       = '0;
        s_a_col2       = '0;
        s_a_col3       = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fail_count     = 0;
        rows_sent      = 0;
        rows_checked   = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed rows against the identity matrix left by reset.
        pending_rows.push_back({32'h0, 32'h0, 32'h0, 32'h0});
        pending_rows.push_back({32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        pending_rows.push_back({32'h3F80_0000, 32'hBF80_0000, 32'h4000_0000, 32'hC000_0000});
        pending_rows.push_back({32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0000_0001, 32'h8000_0001});
        pending_rows.push_back({32'h007F_FFFF, 32'h0080_0000, 32'h807F_FFFF, 32'h8080_0000});
        // Infinity times an off-diagonal zero gives NaN.
        pending_rows.push_back({32'h0, 32'h0, 32'h0, 32'h7F80_0000});
        pending_rows.push_back({32'hFF80_0000, 32'h0, 32'h0, 32'h0});
        pending_rows.push_back({32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0});
        pending_rows.push_back({32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0});
        pending_rows.push_back({32'h0, 32'h0, 32'h7F80_0001, 32'h0});
        pending_rows.push_back('1);
        pending_rows.push_back({32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA});
        drain();

        // Largest normal and smallest subnormal weights: infinity minus
        // infinity and overflow of a product.
        load_matrix(2);
        pending_rows.push_back({32'h7F80_0000, 32'hFF80_0000, 32'h0, 32'h0});
        pending_rows.push_back({32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h0, 32'h0});
        pending_rows.push_back({32'h3F00_0000, 32'h3F00_0000, 32'h0000_0001, 32'h8000_0001});
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            load_matrix((ph < 3) ? ph : 3);
            send_idle_pct  = modes[ph % 4][0];
            recv_stall_pct = modes[ph % 4][1];
            for (int n = 0; n < 118; n++)
                pending_rows.push_back(rand_row());
            drain();
        end

        $display("tb: %0d rows sent, %0d rows checked, over 10 matrix settings", rows_sent,
                 rows_checked);
        $display("tb: covered signed zeros, subnormals, infinities, NaNs and stalls");
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
